FILE: rtl/llgm_pkg.sv
// ----------------------------------------------------------------------------
// llgm_pkg
// Shared types, register codes and saturating 64-bit helpers for the
// midpoint spin update datapath.
// ----------------------------------------------------------------------------
package llgm_pkg;

    typedef logic signed [63:0] t_s64;

    localparam t_s64 S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_s64 S64_MIN = 64'sh8000_0000_0000_0000;
    localparam t_s64 ONE_Q32 = 64'sh0000_0001_0000_0000;

    localparam int CFG_ADDR_W = 3;
    localparam int QUO_W      = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DAMPING     = 3'd0,
        CFG_HALF_STEP   = 3'd1,
        CFG_NOISE_SCALE = 3'd2,
        CFG_CURRENT_X   = 3'd3,
        CFG_CURRENT_Y   = 3'd4,
        CFG_CURRENT_Z   = 3'd5
    } t_cfg_addr;

    function automatic t_s64 sadd(t_s64 a, t_s64 b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (!s[64] && s[63]) begin
            sadd = S64_MAX;
        end else if (s[64] && !s[63]) begin
            sadd = -S64_MAX;
        end else begin
            sadd = s[63:0];
        end
    endfunction

    function automatic t_s64 sneg(t_s64 a);
        sneg = (a == S64_MIN) ? S64_MAX : -a;
    endfunction

    function automatic t_s64 ssub(t_s64 a, t_s64 b);
        ssub = sadd(a, sneg(b));
    endfunction

endpackage

FILE: rtl/llg_midpoint_spin_update_top.sv
// ----------------------------------------------------------------------------
// llg_midpoint_spin_update_top
// Semi-implicit midpoint spin update: forms A from field, current and noise,
// solves (I + [A]x) n1 = b + b x A by Cramer's rule, outputs n1 and midpoint.
// ----------------------------------------------------------------------------
// Fully pipelined: one spin request per clock while o_stall is low. The
// pipeline is built from a chain of three-stage 64-bit multipliers and the
// 32-stage reciprocal of 1+|A|^2, ending in the output register. A stall at the output
// freezes every stage at once; nothing is dropped or repeated. Configuration
// registers reset to zero; write them only while no request is in flight.
// ----------------------------------------------------------------------------
module llg_midpoint_spin_update_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [llgm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [((DATA_WIDTH > 24) ? DATA_WIDTH : 24)-1:0] i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [DATA_WIDTH-1:0]  i_base_x,
    input  logic signed [DATA_WIDTH-1:0]  i_base_y,
    input  logic signed [DATA_WIDTH-1:0]  i_base_z,
    input  logic signed [DATA_WIDTH-1:0]  i_eval_x,
    input  logic signed [DATA_WIDTH-1:0]  i_eval_y,
    input  logic signed [DATA_WIDTH-1:0]  i_eval_z,
    input  logic signed [DATA_WIDTH-1:0]  i_field_x,
    input  logic signed [DATA_WIDTH-1:0]  i_field_y,
    input  logic signed [DATA_WIDTH-1:0]  i_field_z,
    input  logic signed [DATA_WIDTH-1:0]  i_noise_x,
    input  logic signed [DATA_WIDTH-1:0]  i_noise_y,
    input  logic signed [DATA_WIDTH-1:0]  i_noise_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [DATA_WIDTH-1:0]  o_next_x,
    output logic signed [DATA_WIDTH-1:0]  o_next_y,
    output logic signed [DATA_WIDTH-1:0]  o_next_z,
    output logic signed [DATA_WIDTH-1:0]  o_mid_x,
    output logic signed [DATA_WIDTH-1:0]  o_mid_y,
    output logic signed [DATA_WIDTH-1:0]  o_mid_z
);
    import llgm_pkg::*;

    localparam int          DW         = DATA_WIDTH;
    localparam int          LAST       = 60;
    localparam logic [2:0]  NEXT_SHIFT = 3'd3;
    localparam logic [2:0]  MID_SHIFT  = 3'd4;

    function automatic logic signed [DATA_WIDTH-1:0] to_word(t_s64 v, logic [2:0] s);
        logic [63:0] m;
        logic        sat;
        m   = v[63] ? 64'(-v) : 64'(v);
        m   = (m + (64'd1 << (s - 3'd1))) >> s;
        sat = |m[63:DATA_WIDTH-1];
        if (v[63]) begin
            to_word = sat ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : -m[DATA_WIDTH-1:0];
        end else begin
            to_word = sat ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : m[DATA_WIDTH-1:0];
        end
    endfunction

    // configuration
    logic [15:0]            r_damping;
    logic [23:0]            r_half_step;
    logic [23:0]            r_noise_scale;
    logic signed [DW-1:0]   r_cur [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damping     <= '0;
            r_half_step   <= '0;
            r_noise_scale <= '0;
            r_cur[0]      <= '0;
            r_cur[1]      <= '0;
            r_cur[2]      <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_DAMPING:     r_damping     <= i_cfg_wdata[15:0];
                CFG_HALF_STEP:   r_half_step   <= i_cfg_wdata[23:0];
                CFG_NOISE_SCALE: r_noise_scale <= i_cfg_wdata[23:0];
                CFG_CURRENT_X:   r_cur[0]      <= i_cfg_wdata[DW-1:0];
                CFG_CURRENT_Y:   r_cur[1]      <= i_cfg_wdata[DW-1:0];
                CFG_CURRENT_Z:   r_cur[2]      <= i_cfg_wdata[DW-1:0];
                default: ;
            endcase
        end
    end

    t_s64 w_alpha;
    t_s64 w_hs;
    t_s64 w_ns;

    assign w_alpha = t_s64'({r_damping, 16'h0});
    assign w_hs    = t_s64'({r_half_step, 8'h0});
    assign w_ns    = t_s64'({r_noise_scale, 12'h0});

    // pipeline control
    logic            w_en;
    logic [LAST:0]   r_vld;

    assign w_en    = !(r_vld[LAST] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], i_valid};
        end
    end

    // t0: capture request
    logic signed [DW-1:0] r_base  [3];
    logic signed [DW-1:0] r_eval  [3];
    logic signed [DW-1:0] r_field [3];
    logic signed [DW-1:0] r_noise [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_base[0]  <= i_base_x;
            r_base[1]  <= i_base_y;
            r_base[2]  <= i_base_z;
            r_eval[0]  <= i_eval_x;
            r_eval[1]  <= i_eval_y;
            r_eval[2]  <= i_eval_z;
            r_field[0] <= i_field_x;
            r_field[1] <= i_field_y;
            r_field[2] <= i_field_z;
            r_noise[0] <= i_noise_x;
            r_noise[1] <= i_noise_y;
            r_noise[2] <= i_noise_z;
        end
    end

    t_s64 w_n   [3];
    t_s64 w_vec [3][3];
    t_s64 w_g1p [3][3];
    t_s64 w_g1m [3][3];
    t_s64 w_mac [3];
    t_s64 r_x   [3][3];
    t_s64 r_tcn [3];
    t_s64 w_mxh [3];
    t_s64 w_mxr [3];
    t_s64 w_tcn7 [3];
    t_s64 w_xc7  [3];
    t_s64 w_h7   [3];
    t_s64 w_rn7  [3];
    t_s64 r_th  [3];
    t_s64 r_tc  [3];
    t_s64 r_tr  [3];
    t_s64 r_s   [3];
    t_s64 r_tr9 [3];
    t_s64 w_mh  [3];
    t_s64 w_mn  [3];
    t_s64 r_am  [3];
    t_s64 w_b13 [3];
    t_s64 w_bp  [3];
    t_s64 w_bm  [3];
    t_s64 w_sq  [3];
    t_s64 w_pr  [3];
    t_s64 w_a16 [3];
    t_s64 w_b16 [3];
    t_s64 r_ba  [3];
    t_s64 r_b17 [3];
    t_s64 r_a18 [3];
    t_s64 r_b18 [3];
    t_s64 r_a19 [3];
    t_s64 r_b19 [3];
    t_s64 w_a51 [3];
    t_s64 w_a54 [3];
    t_s64 w_b58 [3];
    t_s64 w_np  [3][3];
    t_s64 r_sum1 [3];
    t_s64 r_p2  [3];
    t_s64 r_n1  [3];
    t_s64 r_b59r [3];
    logic signed [DW-1:0] r_next [3];
    logic signed [DW-1:0] r_mid  [3];

    t_s64 r_coef17 [9];
    t_s64 r_coef18 [9];
    t_s64 r_coef19 [9];
    t_s64 w_coef51 [9];
    t_s64 w_g      [9];
    t_s64 r_sqy17;
    t_s64 r_sqz17;
    t_s64 r_d1;
    t_s64 r_sqz18;
    t_s64 r_det;
    t_s64 w_r;
    logic [QUO_W-1:0] w_quo;

    logic [6*DW-1:0]  w_hn_in;
    logic [6*DW-1:0]  w_hn_out;
    logic [6*64-1:0]  w_tx_in;
    logic [6*64-1:0]  w_tx_out;
    logic [3*DW-1:0]  w_b_in;
    logic [3*DW-1:0]  w_b_out;
    logic [6*64-1:0]  w_ab_in;
    logic [6*64-1:0]  w_ab_out;
    logic [12*64-1:0] w_ac_in;
    logic [12*64-1:0] w_ac_out;
    logic [3*64-1:0]  w_a3_in;
    logic [3*64-1:0]  w_a3_out;
    logic [3*64-1:0]  w_bl_in;
    logic [3*64-1:0]  w_bl_out;

    for (genvar i = 0; i < 3; i++) begin : g_vec
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        assign w_n[i]      = t_s64'(r_eval[i]) <<< 3;
        assign w_vec[0][i] = t_s64'(r_field[i]) <<< 9;
        assign w_vec[1][i] = t_s64'(r_cur[i]) <<< 9;
        assign w_vec[2][i] = t_s64'(r_noise[i]) <<< 3;

        // t0 -> t3: eval cross field, current and noise; alpha*current
        for (genvar v = 0; v < 3; v++) begin : g_cross
            llgm_mul #(.SHIFT(32)) u_mp (
                .i_clk(i_clk), .i_en(w_en),
                .i_a(w_n[J]), .i_b(w_vec[v][K]), .o_p(w_g1p[v][i])
            );
            llgm_mul #(.SHIFT(32)) u_mm (
                .i_clk(i_clk), .i_en(w_en),
                .i_a(w_n[K]), .i_b(w_vec[v][J]), .o_p(w_g1m[v][i])
            );
        end
        llgm_mul #(.SHIFT(32)) u_mac (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(w_alpha), .i_b(w_vec[1][i]), .o_p(w_mac[i])
        );

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_x[0][i] <= ssub(w_g1p[0][i], w_g1m[0][i]);
                r_x[1][i] <= ssub(w_g1p[1][i], w_g1m[1][i]);
                r_x[2][i] <= ssub(w_g1p[2][i], w_g1m[2][i]);
                r_tcn[i]  <= sneg(w_mac[i]);
            end
        end

        // t4 -> t7: damping terms
        llgm_mul #(.SHIFT(32)) u_mxh (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(w_alpha), .i_b(r_x[0][i]), .o_p(w_mxh[i])
        );
        llgm_mul #(.SHIFT(32)) u_mxr (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(w_alpha), .i_b(r_x[2][i]), .o_p(w_mxr[i])
        );

        assign w_hn_in[i*DW +: DW]     = r_field[i];
        assign w_hn_in[(i+3)*DW +: DW] = r_noise[i];
        assign w_h7[i]  = t_s64'($signed(w_hn_out[i*DW +: DW])) <<< 9;
        assign w_rn7[i] = t_s64'($signed(w_hn_out[(i+3)*DW +: DW])) <<< 3;

        assign w_tx_in[i*64 +: 64]     = r_tcn[i];
        assign w_tx_in[(i+3)*64 +: 64] = r_x[1][i];
        assign w_tcn7[i] = w_tx_out[i*64 +: 64];
        assign w_xc7[i]  = w_tx_out[(i+3)*64 +: 64];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_th[i]  <= ssub(sneg(w_h7[i]), w_mxh[i]);
                r_tc[i]  <= sadd(w_tcn7[i], w_xc7[i]);
                r_tr[i]  <= ssub(sneg(w_rn7[i]), w_mxr[i]);
                r_s[i]   <= sadd(r_th[i], r_tc[i]);
                r_tr9[i] <= r_tr[i];
            end
        end

        // t9 -> t12: scale by half step and noise scale
        llgm_mul #(.SHIFT(32)) u_mh (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(w_hs), .i_b(r_s[i]), .o_p(w_mh[i])
        );
        llgm_mul #(.SHIFT(32)) u_mn (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(w_ns), .i_b(r_tr9[i]), .o_p(w_mn[i])
        );

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_am[i] <= sadd(w_mh[i], w_mn[i]);
            end
        end

        assign w_b_in[i*DW +: DW] = r_base[i];
        assign w_b13[i] = t_s64'($signed(w_b_out[i*DW +: DW])) <<< 3;

        // t13 -> t16: base cross A, squares and pair products
        llgm_mul #(.SHIFT(32)) u_bp (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(w_b13[J]), .i_b(r_am[K]), .o_p(w_bp[i])
        );
        llgm_mul #(.SHIFT(32)) u_bm (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(w_b13[K]), .i_b(r_am[J]), .o_p(w_bm[i])
        );
        llgm_mul #(.SHIFT(32)) u_sq (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(r_am[i]), .i_b(r_am[i]), .o_p(w_sq[i])
        );
        llgm_mul #(.SHIFT(32)) u_pr (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(r_am[J]), .i_b(r_am[K]), .o_p(w_pr[i])
        );

        assign w_ab_in[i*64 +: 64]     = r_am[i];
        assign w_ab_in[(i+3)*64 +: 64] = w_b13[i];
        assign w_a16[i] = w_ab_out[i*64 +: 64];
        assign w_b16[i] = w_ab_out[(i+3)*64 +: 64];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ba[i]  <= ssub(w_bp[i], w_bm[i]);
                r_b17[i] <= w_b16[i];
                r_a18[i] <= sadd(r_b17[i], r_ba[i]);
                r_b18[i] <= r_b17[i];
                r_a19[i] <= r_a18[i];
                r_b19[i] <= r_b18[i];
            end
        end

        assign w_ac_in[(i+9)*64 +: 64] = r_a19[i];
        assign w_a51[i] = w_ac_out[(i+9)*64 +: 64];

        assign w_a3_in[i*64 +: 64] = w_a51[i];
        assign w_a54[i] = w_a3_out[i*64 +: 64];

        assign w_bl_in[i*64 +: 64] = r_b19[i];
        assign w_b58[i] = w_bl_out[i*64 +: 64];

        // t54 -> t57: row i of the solve
        for (genvar j = 0; j < 3; j++) begin : g_row
            llgm_mul #(.SHIFT(32)) u_np (
                .i_clk(i_clk), .i_en(w_en),
                .i_a(w_a54[j]), .i_b(w_g[3*i+j]), .o_p(w_np[i][j])
            );
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sum1[i] <= sadd(w_np[i][0], w_np[i][1]);
                r_p2[i]   <= w_np[i][2];
                r_n1[i]   <= sadd(r_sum1[i], r_p2[i]);
                r_b59r[i] <= w_b58[i];
                r_next[i] <= to_word(r_n1[i], NEXT_SHIFT);
                r_mid[i]  <= to_word(sadd(r_b59r[i], r_n1[i]), MID_SHIFT);
            end
        end
    end

    llgm_dly #(.WIDTH(6*DW), .DEPTH(7)) u_dly_hn (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_hn_in), .o_q(w_hn_out)
    );
    llgm_dly #(.WIDTH(6*64), .DEPTH(3)) u_dly_tx (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_tx_in), .o_q(w_tx_out)
    );
    llgm_dly #(.WIDTH(3*DW), .DEPTH(13)) u_dly_base (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_b_in), .o_q(w_b_out)
    );
    llgm_dly #(.WIDTH(6*64), .DEPTH(3)) u_dly_ab (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_ab_in), .o_q(w_ab_out)
    );
    llgm_dly #(.WIDTH(12*64), .DEPTH(QUO_W)) u_dly_ac (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_ac_in), .o_q(w_ac_out)
    );
    llgm_dly #(.WIDTH(3*64), .DEPTH(3)) u_dly_a3 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_a3_in), .o_q(w_a3_out)
    );
    llgm_dly #(.WIDTH(3*64), .DEPTH(39)) u_dly_bl (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_bl_in), .o_q(w_bl_out)
    );

    // t17..t19: Cramer coefficients and determinant
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_coef17[0] <= sadd(ONE_Q32, w_sq[0]);
            r_coef17[1] <= sadd(w_pr[2], w_a16[2]);
            r_coef17[2] <= ssub(w_pr[1], w_a16[1]);
            r_coef17[3] <= ssub(w_pr[2], w_a16[2]);
            r_coef17[4] <= sadd(ONE_Q32, w_sq[1]);
            r_coef17[5] <= sadd(w_pr[0], w_a16[0]);
            r_coef17[6] <= sadd(w_pr[1], w_a16[1]);
            r_coef17[7] <= ssub(w_pr[0], w_a16[0]);
            r_coef17[8] <= sadd(ONE_Q32, w_sq[2]);
            r_sqy17     <= w_sq[1];
            r_sqz17     <= w_sq[2];
            r_d1        <= sadd(r_coef17[0], r_sqy17);
            r_sqz18     <= r_sqz17;
            r_det       <= sadd(r_d1, r_sqz18);
            r_coef18    <= r_coef17;
            r_coef19    <= r_coef18;
        end
    end

    llgm_recip u_recip (
        .i_clk(i_clk), .i_en(w_en), .i_det(r_det), .o_quo(w_quo)
    );

    assign w_r = t_s64'({32'b0, w_quo});

    for (genvar c = 0; c < 9; c++) begin : g_coef
        assign w_ac_in[c*64 +: 64] = r_coef19[c];
        assign w_coef51[c] = w_ac_out[c*64 +: 64];

        llgm_mul #(.SHIFT(31)) u_g (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(w_coef51[c]), .i_b(w_r), .o_p(w_g[c])
        );
    end

    assign o_next_x = r_next[0];
    assign o_next_y = r_next[1];
    assign o_next_z = r_next[2];
    assign o_mid_x  = r_mid[0];
    assign o_mid_y  = r_mid[1];
    assign o_mid_z  = r_mid[2];

endmodule

FILE: rtl/llgm_dly.sv
// ----------------------------------------------------------------------------
// llgm_dly
// Enabled delay line that carries payload alongside the datapath stages.
// ----------------------------------------------------------------------------
module llgm_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

FILE: rtl/llgm_mul.sv
// ----------------------------------------------------------------------------
// llgm_mul
// Three-stage signed 64x64 multiply built from four 32x32 partial products,
// rounded to nearest (ties away from zero) after a right shift, saturated.
// ----------------------------------------------------------------------------
module llgm_mul #(
    parameter int SHIFT = 32
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  llgm_pkg::t_s64 i_a,
    input  llgm_pkg::t_s64 i_b,
    output llgm_pkg::t_s64 o_p
);
    import llgm_pkg::*;

    localparam logic [127:0] RND = 128'(1) << (SHIFT - 1);

    logic [63:0]  w_ua;
    logic [63:0]  w_ub;
    logic [63:0]  r_p00;
    logic [63:0]  r_p01;
    logic [63:0]  r_p10;
    logic [63:0]  r_p11;
    logic         r_neg1;
    logic [127:0] r_sum;
    logic         r_neg2;
    logic [127:0] w_quo;
    logic [62:0]  w_mag;
    t_s64         r_p;

    assign w_ua  = i_a[63] ? 64'(-i_a) : 64'(i_a);
    assign w_ub  = i_b[63] ? 64'(-i_b) : 64'(i_b);
    assign w_quo = r_sum >> SHIFT;
    assign w_mag = (|w_quo[127:63]) ? {63{1'b1}} : w_quo[62:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00  <= w_ua[31:0]  * w_ub[31:0];
            r_p01  <= w_ua[31:0]  * w_ub[63:32];
            r_p10  <= w_ua[63:32] * w_ub[31:0];
            r_p11  <= w_ua[63:32] * w_ub[63:32];
            r_neg1 <= i_a[63] ^ i_b[63];
            r_sum  <= {r_p11, 64'b0} + {32'b0, r_p01, 32'b0}
                    + {32'b0, r_p10, 32'b0} + {64'b0, r_p00} + RND;
            r_neg2 <= r_neg1;
            r_p    <= r_neg2 ? -t_s64'({1'b0, w_mag}) : t_s64'({1'b0, w_mag});
        end
    end

    assign o_p = r_p;

endmodule

FILE: rtl/llgm_recip.sv
// ----------------------------------------------------------------------------
// llgm_recip
// Pipelined restoring divider: round(2^63 / det) for det >= 2^32, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module llgm_recip (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  llgm_pkg::t_s64             i_det,
    output logic [llgm_pkg::QUO_W-1:0] o_quo
);
    import llgm_pkg::*;

    logic [63:0]      r_rem [QUO_W];
    logic [QUO_W-1:0] r_lo  [QUO_W];
    logic [62:0]      r_det [QUO_W];
    logic [QUO_W-1:0] r_q   [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [63:0]      p_rem;
        logic [QUO_W-1:0] p_lo;
        logic [62:0]      p_det;
        logic [QUO_W-1:0] p_q;
        logic [64:0]      w_trial;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign p_rem = {32'b0, 1'b1, i_det[63:33]};
            assign p_lo  = i_det[32:1];
            assign p_det = i_det[62:0];
            assign p_q   = '0;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_lo  = r_lo[k-1];
            assign p_det = r_det[k-1];
            assign p_q   = r_q[k-1];
        end

        assign w_trial = {p_rem, p_lo[QUO_W-1]};
        assign w_ge    = w_trial >= {2'b0, p_det};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? 64'(w_trial - {2'b0, p_det}) : w_trial[63:0];
                r_lo[k]  <= {p_lo[QUO_W-2:0], 1'b0};
                r_det[k] <= p_det;
                r_q[k]   <= {p_q[QUO_W-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_q[QUO_W-1];

endmodule
